// ===== rtl/fbs_pkg.sv =====
`default_nettype none
package fbs_pkg;

  localparam int BLOCK_SIZE        = 32;
  localparam int SLOT_NUM          = 16;
  localparam int FILE_COUNT_DEF    = 12;
  localparam int BLOCK_COUNT_DEF   = 256;
  localparam int INDEX_ENTRIES_DEF = 16;

  localparam logic [8:0] LINK_NONE = 9'h1FF;

  localparam logic [2:0] FN_FORMAT = 3'd0;
  localparam logic [2:0] FN_CREATE = 3'd1;
  localparam logic [2:0] FN_DELETE = 3'd2;
  localparam logic [2:0] FN_PUT    = 3'd3;
  localparam logic [2:0] FN_GET    = 3'd4;

  localparam logic [1:0] OC_OK    = 2'd0;
  localparam logic [1:0] OC_POS   = 2'd1;
  localparam logic [1:0] OC_NOBLK = 2'd2;
  localparam logic [1:0] OC_SLOT  = 2'd3;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] file_slot;
    logic [9:0] position;
    logic [7:0] write_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [1:0]  outcome;
    logic [9:0]  file_size;
    logic        slot_in_use;
    logic        at_end;
    logic [10:0] next_position;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/fbs_ram.sv =====
`default_nettype none
module fbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/file_block_store_engine_core.sv =====
`default_nettype none
// Channel   Ports                          Moves
// input     in_valid  in_stall  in_req     one command request (format .. query)
// result    out_valid out_stall out_rsp    one response per request
//
// Requests are taken only while the sequencer is idle; one request is in work at a time.
// Query or bad slot answers straight from decode. A direct put writes the byte in
// decode and a direct get reads it; a put or get past the direct region first reads
// the two-byte pointer from the index block. Each new block takes a link read plus a
// 32-byte 0xFF fill, so a put may create both the index block and a data block.
// Create and delete read the index entries up to the first invalid pointer (at most 16)
// and free the index block, if there is one, then clear the slot's 32-byte direct region.
// Format and reset run a clear of the 512-byte direct byte region (in_stall held).
// The response register lets the next request in while the last response is stalled.
module file_block_store_engine_core #(
  parameter int FILE_COUNT    = fbs_pkg::FILE_COUNT_DEF,
  parameter int BLOCK_COUNT   = fbs_pkg::BLOCK_COUNT_DEF,
  parameter int INDEX_ENTRIES = fbs_pkg::INDEX_ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire fbs_pkg::req_t in_req,
  output logic              out_valid,
  input  wire logic         out_stall,
  output fbs_pkg::rsp_t     out_rsp
);
  import fbs_pkg::*;

  localparam int POS_LIMIT  = BLOCK_SIZE * (1 + INDEX_ENTRIES);
  localparam int DIR_BASE   = BLOCK_COUNT * BLOCK_SIZE;
  localparam int DATA_DEPTH = DIR_BASE + SLOT_NUM * BLOCK_SIZE;
  localparam int DAW        = $clog2(DATA_DEPTH);
  localparam int LAW        = $clog2(BLOCK_COUNT);
  localparam int DIR_LAST   = SLOT_NUM * BLOCK_SIZE - 1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DEC, ST_LNK, ST_TAKE, ST_TAKE2, ST_SWEEP, ST_PIB, ST_PWLO,
    ST_PWHI, ST_PWD, ST_RLO, ST_RHI, ST_RCHK, ST_GRD, ST_GIVE, ST_REL, ST_FIN
  } state_t;

  // sequencer state
  state_t     state_r, state_nxt, ret_r, ret_nxt;
  req_t       req_r, req_nxt;
  logic [8:0] head_r, head_nxt;
  logic [8:0] tb_r, tb_nxt;
  logic [8:0] cur_ib_r, cur_ib_nxt;
  logic [8:0] p_r, p_nxt;
  logic [3:0] ent_r, ent_nxt;
  logic [7:0] lo_r, lo_nxt;
  logic       tk_idx_r, tk_idx_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic [1:0] oc_r, oc_nxt;
  logic [10:0] np_r, np_nxt;
  logic [DAW-1:0] sw_base_r, sw_base_nxt;
  logic [9:0] sw_cnt_r, sw_cnt_nxt, sw_last_r, sw_last_nxt;
  logic [7:0] sw_data_r, sw_data_nxt;

  // per-slot metadata
  logic       used_r [SLOT_NUM];
  logic [9:0] size_r [SLOT_NUM];
  logic [8:0] ib_r   [SLOT_NUM];
  logic       used_nxt [SLOT_NUM];
  logic [9:0] size_nxt [SLOT_NUM];
  logic [8:0] ib_nxt   [SLOT_NUM];

  logic out_valid_r, out_valid_nxt;
  rsp_t out_rsp_r, out_rsp_nxt;

  // memory ports
  logic           d_we;
  logic [DAW-1:0] d_waddr, d_raddr;
  logic [7:0]     d_wdata, d_rdata;
  logic           l_we, lvld_clr;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [8:0]     l_wdata, l_rdata;
  logic           lvld_r [BLOCK_COUNT];
  logic           lq_vld_r;
  logic [LAW-1:0] lq_addr_r;
  logic [8:0]     link_q;

  logic [3:0]  s;
  logic [9:0]  pos;
  logic [15:0] p16;
  logic        p_ok;

  function automatic logic [DAW-1:0] blk_addr(input logic [8:0] b, input logic [4:0] off);
    return DAW'({b[LAW-1:0], off});
  endfunction

  function automatic logic [DAW-1:0] dir_addr(input logic [3:0] sl, input logic [4:0] off);
    return DAW'(DIR_BASE) + DAW'({sl, off});
  endfunction

  function automatic logic [8:0] link_dflt(input logic [LAW-1:0] a);
    logic [8:0] r;
    r = LINK_NONE;
    if (int'(a) + 1 < BLOCK_COUNT) begin
      r = 9'(int'(a) + 1);
    end
    return r;
  endfunction

  fbs_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  fbs_ram #(.WIDTH(9), .DEPTH(BLOCK_COUNT)) u_link (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  // a never-written link entry reads as its format value
  assign link_q = lq_vld_r ? l_rdata : link_dflt(lq_addr_r);

  assign s    = req_r.file_slot;
  assign pos  = req_r.position;
  assign p16  = {d_rdata, lo_r};
  assign p_ok = (int'(p16) < BLOCK_COUNT);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    req_nxt     = req_r;
    head_nxt    = head_r;
    tb_nxt      = tb_r;
    cur_ib_nxt  = cur_ib_r;
    p_nxt       = p_r;
    ent_nxt     = ent_r;
    lo_nxt      = lo_r;
    tk_idx_nxt  = tk_idx_r;
    rd_nxt      = rd_r;
    oc_nxt      = oc_r;
    np_nxt      = np_r;
    sw_base_nxt = sw_base_r;
    sw_cnt_nxt  = sw_cnt_r;
    sw_last_nxt = sw_last_r;
    sw_data_nxt = sw_data_r;
    for (int i = 0; i < SLOT_NUM; i++) begin
      used_nxt[i] = used_r[i];
      size_nxt[i] = size_r[i];
      ib_nxt[i]   = ib_r[i];
    end
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    d_we     = 1'b0;
    d_waddr  = '0;
    d_wdata  = '0;
    d_raddr  = '0;
    l_we     = 1'b0;
    l_waddr  = '0;
    l_wdata  = '0;
    l_raddr  = '0;
    lvld_clr = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        rd_nxt = '0;
        oc_nxt = OC_OK;
        np_nxt = {1'b0, pos};
        cur_ib_nxt = ib_r[s];
        state_nxt = ST_FIN;
        if (req_r.func == FN_FORMAT) begin
          head_nxt = '0;
          lvld_clr = 1'b1;
          for (int i = 0; i < SLOT_NUM; i++) begin
            used_nxt[i] = 1'b0;
            size_nxt[i] = '0;
            ib_nxt[i]   = LINK_NONE;
          end
          sw_base_nxt = DAW'(DIR_BASE);
          sw_cnt_nxt  = '0;
          sw_last_nxt = 10'(DIR_LAST);
          sw_data_nxt = 8'h00;
          ret_nxt     = ST_FIN;
          state_nxt   = ST_SWEEP;
        end else if (req_r.func <= FN_GET && int'(s) >= FILE_COUNT) begin
          oc_nxt = OC_SLOT;
        end else if (req_r.func == FN_CREATE || req_r.func == FN_DELETE) begin
          ent_nxt   = '0;
          state_nxt = (int'(ib_r[s]) < BLOCK_COUNT) ? ST_RLO : ST_REL;
        end else if ((req_r.func == FN_PUT || req_r.func == FN_GET)
                     && int'(pos) >= POS_LIMIT) begin
          oc_nxt = OC_POS;
        end else if (req_r.func == FN_PUT) begin
          if (pos < 10'd32) begin
            d_we    = 1'b1;
            d_waddr = dir_addr(s, pos[4:0]);
            d_wdata = req_r.write_byte;
            if (pos >= size_r[s] && int'(size_r[s]) < POS_LIMIT) begin
              size_nxt[s] = size_r[s] + 10'd1;
            end
            np_nxt = {1'b0, pos} + 11'd1;
          end else begin
            ent_nxt = 4'(pos[9:5] - 5'd1);
            if (int'(ib_r[s]) < BLOCK_COUNT) begin
              state_nxt = ST_RLO;
            end else if (int'(head_r) >= BLOCK_COUNT) begin
              oc_nxt = OC_NOBLK;
            end else begin
              // check that a second block follows the head
              l_raddr   = head_r[LAW-1:0];
              state_nxt = ST_LNK;
            end
          end
        end else if (req_r.func == FN_GET) begin
          if (pos < 10'd32) begin
            d_raddr   = dir_addr(s, pos[4:0]);
            state_nxt = ST_GRD;
          end else begin
            ent_nxt = 4'(pos[9:5] - 5'd1);
            if (int'(ib_r[s]) < BLOCK_COUNT) begin
              state_nxt = ST_RLO;
            end
          end
        end
      end
      ST_LNK: begin
        if (int'(link_q) < BLOCK_COUNT) begin
          tk_idx_nxt = 1'b1;
          state_nxt  = ST_TAKE;
        end else begin
          oc_nxt    = OC_NOBLK;
          state_nxt = ST_FIN;
        end
      end
      ST_TAKE: begin
        l_raddr   = head_r[LAW-1:0];
        state_nxt = ST_TAKE2;
      end
      ST_TAKE2: begin
        // pop the head and fill the new block with 0xFF
        head_nxt    = link_q;
        tb_nxt      = head_r;
        sw_base_nxt = blk_addr(head_r, 5'd0);
        sw_cnt_nxt  = '0;
        sw_last_nxt = 10'(BLOCK_SIZE - 1);
        sw_data_nxt = 8'hFF;
        ret_nxt     = tk_idx_r ? ST_PIB : ST_PWLO;
        state_nxt   = ST_SWEEP;
      end
      ST_SWEEP: begin
        d_we       = 1'b1;
        d_waddr    = sw_base_r + DAW'(sw_cnt_r);
        d_wdata    = sw_data_r;
        sw_cnt_nxt = sw_cnt_r + 10'd1;
        if (sw_cnt_r == sw_last_r) begin
          state_nxt = ret_r;
        end
      end
      ST_PIB: begin
        ib_nxt[s]  = tb_r;
        cur_ib_nxt = tb_r;
        tk_idx_nxt = 1'b0;
        state_nxt  = ST_TAKE;
      end
      ST_PWLO: begin
        d_we      = 1'b1;
        d_waddr   = blk_addr(cur_ib_r, {ent_r, 1'b0});
        d_wdata   = tb_r[7:0];
        p_nxt     = tb_r;
        state_nxt = ST_PWHI;
      end
      ST_PWHI: begin
        d_we      = 1'b1;
        d_waddr   = blk_addr(cur_ib_r, {ent_r, 1'b1});
        d_wdata   = {7'd0, tb_r[8]};
        state_nxt = ST_PWD;
      end
      ST_PWD: begin
        d_we    = 1'b1;
        d_waddr = blk_addr(p_r, pos[4:0]);
        d_wdata = req_r.write_byte;
        if (pos >= size_r[s] && int'(size_r[s]) < POS_LIMIT) begin
          size_nxt[s] = size_r[s] + 10'd1;
        end
        np_nxt    = {1'b0, pos} + 11'd1;
        state_nxt = ST_FIN;
      end
      ST_RLO: begin
        d_raddr   = blk_addr(cur_ib_r, {ent_r, 1'b0});
        state_nxt = ST_RHI;
      end
      ST_RHI: begin
        d_raddr   = blk_addr(cur_ib_r, {ent_r, 1'b1});
        lo_nxt    = d_rdata;
        state_nxt = ST_RCHK;
      end
      ST_RCHK: begin
        if (req_r.func == FN_CREATE || req_r.func == FN_DELETE) begin
          if (p_ok) begin
            // push the data block back on the free list
            l_we     = 1'b1;
            l_waddr  = p16[LAW-1:0];
            l_wdata  = head_r;
            head_nxt = p16[8:0];
            ent_nxt  = ent_r + 4'd1;
            state_nxt = (ent_r == 4'(INDEX_ENTRIES - 1)) ? ST_GIVE : ST_RLO;
          end else begin
            state_nxt = ST_GIVE;
          end
        end else if (req_r.func == FN_PUT) begin
          if (p_ok) begin
            p_nxt     = p16[8:0];
            state_nxt = ST_PWD;
          end else if (int'(head_r) >= BLOCK_COUNT) begin
            oc_nxt    = OC_NOBLK;
            state_nxt = ST_FIN;
          end else begin
            tk_idx_nxt = 1'b0;
            state_nxt  = ST_TAKE;
          end
        end else begin
          if (p_ok) begin
            d_raddr   = blk_addr(p16[8:0], pos[4:0]);
            state_nxt = ST_GRD;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_GRD: begin
        rd_nxt    = d_rdata;
        np_nxt    = {1'b0, pos} + 11'd1;
        state_nxt = ST_FIN;
      end
      ST_GIVE: begin
        l_we      = 1'b1;
        l_waddr   = cur_ib_r[LAW-1:0];
        l_wdata   = head_r;
        head_nxt  = cur_ib_r;
        state_nxt = ST_REL;
      end
      ST_REL: begin
        used_nxt[s] = (req_r.func == FN_CREATE);
        size_nxt[s] = '0;
        ib_nxt[s]   = LINK_NONE;
        sw_base_nxt = dir_addr(s, 5'd0);
        sw_cnt_nxt  = '0;
        sw_last_nxt = 10'(BLOCK_SIZE - 1);
        sw_data_nxt = 8'h00;
        ret_nxt     = ST_FIN;
        state_nxt   = ST_SWEEP;
      end
      ST_FIN: begin
        // hold until the response register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_rsp_nxt.read_byte     = rd_r;
          out_rsp_nxt.outcome       = oc_r;
          out_rsp_nxt.file_size     = size_r[s];
          out_rsp_nxt.slot_in_use   = used_r[s];
          out_rsp_nxt.at_end        = (np_r >= {1'b0, size_r[s]});
          out_rsp_nxt.next_position = np_r;
          state_nxt                 = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // reset runs the same clear as format
      state_r     <= ST_SWEEP;
      ret_r       <= ST_IDLE;
      head_r      <= '0;
      sw_base_r   <= DAW'(DIR_BASE);
      sw_cnt_r    <= '0;
      sw_last_r   <= 10'(DIR_LAST);
      sw_data_r   <= 8'h00;
      tk_idx_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_NUM; i++) begin
        used_r[i] <= 1'b0;
        size_r[i] <= '0;
        ib_r[i]   <= LINK_NONE;
      end
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        lvld_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      head_r      <= head_nxt;
      sw_base_r   <= sw_base_nxt;
      sw_cnt_r    <= sw_cnt_nxt;
      sw_last_r   <= sw_last_nxt;
      sw_data_r   <= sw_data_nxt;
      tk_idx_r    <= tk_idx_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < SLOT_NUM; i++) begin
        used_r[i] <= used_nxt[i];
        size_r[i] <= size_nxt[i];
        ib_r[i]   <= ib_nxt[i];
      end
      for (int i = 0; i < BLOCK_COUNT; i++) begin
        if (lvld_clr) begin
          lvld_r[i] <= 1'b0;
        end else if (l_we && int'(l_waddr) == i) begin
          lvld_r[i] <= 1'b1;
        end
      end
    end
    req_r     <= req_nxt;
    tb_r      <= tb_nxt;
    cur_ib_r  <= cur_ib_nxt;
    p_r       <= p_nxt;
    ent_r     <= ent_nxt;
    lo_r      <= lo_nxt;
    rd_r      <= rd_nxt;
    oc_r      <= oc_nxt;
    np_r      <= np_nxt;
    out_rsp_r <= out_rsp_nxt;
    lq_vld_r  <= lvld_r[l_raddr];
    lq_addr_r <= l_raddr;
  end

  a_take_real_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAKE) |-> (int'(head_r) < BLOCK_COUNT))
    else $error("allocation from an empty free list");

  a_write_real_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PWD) |-> (int'(p_r) < BLOCK_COUNT))
    else $error("byte write through an invalid block pointer");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (int'(size_r[s]) <= POS_LIMIT))
    else $error("file size beyond position limit");

  a_resp_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && out_stall) |=> (state_r == ST_FIN))
    else $error("response finished over a stalled response");

endmodule
`default_nettype wire

// ===== tb/sv/file_block_store_engine_core_tb.sv =====
`timescale 1ns / 100ps

module file_block_store_engine_core_tb;
  import fbs_pkg::*;

  // Geometry of the instance under test (the default parameters)
  localparam int FILES     = FILE_COUNT_DEF;
  localparam int BLOCKS    = BLOCK_COUNT_DEF;
  localparam int ENTRIES   = INDEX_ENTRIES_DEF;
  localparam int POS_LIMIT = BLOCK_SIZE * (1 + ENTRIES);

  // Codes the package leaves out: query and the two unused function codes
  localparam logic [2:0] FN_QUERY = 3'd5;
  localparam logic [2:0] FN_RSVD6 = 3'd6;
  localparam logic [2:0] FN_RSVD7 = 3'd7;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  req_t  in_req;
  logic  out_valid;
  logic  out_stall;
  rsp_t  out_rsp;

  file_block_store_engine_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mirror of the file store, updated as each request is accepted
  logic [8:0] fs_free_head;
  logic [8:0] fs_free_next [BLOCKS];
  logic       fs_used      [SLOT_NUM];
  logic [9:0] fs_size      [SLOT_NUM];
  logic [8:0] fs_index     [SLOT_NUM];
  logic [7:0] fs_direct    [SLOT_NUM * BLOCK_SIZE];
  logic [7:0] fs_blk       [BLOCKS * BLOCK_SIZE];

  rsp_t expected_rsps[$];
  int   fail_count;
  int   rsp_count;
  int   req_count;
  int   noblk_seen;
  int   hold_cycles;   // pending long receiver hold-off, in cycles
  bit   calm;          // suppress random idling on both sides

  function automatic bit blk_valid(input int b);
    return b < BLOCKS;
  endfunction

  function automatic int ptr_get(input int ib, input int ent);
    int a;
    a = (ib & 255) * BLOCK_SIZE + (ent & 15) * 2;
    return int'(fs_blk[a]) | (int'(fs_blk[a + 1]) << 8);
  endfunction

  task automatic ptr_set(input int ib, input int ent, input int p);
    int a;
    a = (ib & 255) * BLOCK_SIZE + (ent & 15) * 2;
    fs_blk[a]     = p[7:0];
    fs_blk[a + 1] = p[15:8];
  endtask

  // Pop the free list head and fill the block with 0xFF
  task automatic pop_block(output int b);
    b = fs_free_head;
    fs_free_head = fs_free_next[b & 255] & LINK_NONE;
    for (int i = 0; i < BLOCK_SIZE; i++) fs_blk[(b & 255) * BLOCK_SIZE + i] = 8'hFF;
  endtask

  task automatic push_block(input int b);
    fs_free_next[b & 255] = fs_free_head;
    fs_free_head = b[8:0];
  endtask

  // Free data blocks up to the first invalid pointer, then the index block
  task automatic free_slot(input int s);
    int ib;
    int p;
    ib = fs_index[s];
    if (blk_valid(ib)) begin
      for (int e = 0; e < ENTRIES; e++) begin
        p = ptr_get(ib, e);
        if (!blk_valid(p)) break;
        push_block(p);
      end
      push_block(ib);
    end
    fs_used[s]  = 1'b0;
    fs_size[s]  = '0;
    fs_index[s] = LINK_NONE;
    for (int i = 0; i < BLOCK_SIZE; i++) fs_direct[s * BLOCK_SIZE + i] = '0;
  endtask

  task automatic format_store();
    fs_free_head = '0;
    for (int i = 0; i < BLOCKS; i++) fs_free_next[i] = (i + 1 < BLOCKS) ? 9'(i + 1) : LINK_NONE;
    for (int s = 0; s < SLOT_NUM; s++) begin
      fs_used[s]  = 1'b0;
      fs_size[s]  = '0;
      fs_index[s] = LINK_NONE;
    end
    foreach (fs_direct[i]) fs_direct[i] = '0;
    foreach (fs_blk[i]) fs_blk[i] = '0;
  endtask

  // Apply one request to the mirror and work out its response
  task automatic store_apply(input req_t r, output rsp_t e);
    int  s, pos, rd, nxt, ib, p, ent, off, need;
    logic [1:0] oc;
    bit  ok;
    s   = r.file_slot;
    pos = r.position;
    rd  = 0;
    oc  = OC_OK;
    nxt = pos;
    if (r.func == FN_FORMAT) begin
      format_store();
    end else if (r.func <= FN_GET && s >= FILES) begin
      oc = OC_SLOT;
    end else if (r.func == FN_CREATE) begin
      free_slot(s);
      fs_used[s] = 1'b1;
    end else if (r.func == FN_DELETE) begin
      free_slot(s);
    end else if ((r.func == FN_PUT || r.func == FN_GET) && pos >= POS_LIMIT) begin
      oc = OC_POS;
    end else if (r.func == FN_PUT) begin
      ok = 1'b1;
      if (pos >= BLOCK_SIZE) begin
        ent = pos / BLOCK_SIZE - 1;
        off = pos % BLOCK_SIZE;
        ib  = fs_index[s];
        if (!blk_valid(ib)) need = 2;
        else need = blk_valid(ptr_get(ib, ent)) ? 0 : 1;
        if (need >= 1 && !blk_valid(fs_free_head)) ok = 1'b0;
        if (need == 2 && ok && !blk_valid(fs_free_next[fs_free_head[7:0]])) ok = 1'b0;
        if (ok) begin
          if (!blk_valid(ib)) begin
            pop_block(ib);
            fs_index[s] = ib[8:0];
          end
          p = ptr_get(ib, ent);
          if (!blk_valid(p)) begin
            pop_block(p);
            ptr_set(ib, ent, p);
          end
          fs_blk[(p & 255) * BLOCK_SIZE + off] = r.write_byte;
        end
      end else begin
        fs_direct[s * BLOCK_SIZE + pos] = r.write_byte;
      end
      if (ok) begin
        if (pos >= fs_size[s] && fs_size[s] < POS_LIMIT) fs_size[s] = fs_size[s] + 1'b1;
        nxt = pos + 1;
      end else begin
        oc = OC_NOBLK;
      end
    end else if (r.func == FN_GET) begin
      if (pos < BLOCK_SIZE) begin
        rd  = fs_direct[s * BLOCK_SIZE + pos];
        nxt = pos + 1;
      end else begin
        ent = pos / BLOCK_SIZE - 1;
        off = pos % BLOCK_SIZE;
        ib  = fs_index[s];
        if (blk_valid(ib)) begin
          p = ptr_get(ib, ent);
          if (blk_valid(p)) begin
            rd  = fs_blk[(p & 255) * BLOCK_SIZE + off];
            nxt = pos + 1;
          end
        end
      end
    end
    e.read_byte     = rd[7:0];
    e.outcome       = oc;
    e.file_size     = fs_size[s];
    e.slot_in_use   = fs_used[s];
    e.at_end        = (nxt >= fs_size[s]);
    e.next_position = nxt[10:0];
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("mismatch on response %0d: %s is %0d, expected %0d", rsp_count, what, got, want);
  endtask

  // Offer one request; hold it until the block takes it, then predict
  task automatic send_req(input logic [2:0] func, input int slot, input int pos, input int wb);
    req_t r;
    rsp_t e;
    int   gap;
    r.func       = func;
    r.file_slot  = slot[3:0];
    r.position   = pos[9:0];
    r.write_byte = wb[7:0];
    gap = (!calm && $urandom_range(99) < 8) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    store_apply(r, e);
    if (e.outcome == OC_NOBLK) noblk_seen++;
    expected_rsps.push_back(e);
    req_count++;
  endtask

  // Drop valid and wait until every expected response has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  // Receiver: long hold-offs on request, otherwise random stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 8);
      end
    end
  end

  // Check each accepted response against the oldest expectation
  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        fail_count++;
        $display("response with nothing expected: %h", out_rsp);
      end else begin
        e = expected_rsps.pop_front();
        if (out_rsp.read_byte !== e.read_byte)
          report_mismatch("read_byte", out_rsp.read_byte, e.read_byte);
        if (out_rsp.outcome !== e.outcome)
          report_mismatch("outcome", out_rsp.outcome, e.outcome);
        if (out_rsp.file_size !== e.file_size)
          report_mismatch("file_size", out_rsp.file_size, e.file_size);
        if (out_rsp.slot_in_use !== e.slot_in_use)
          report_mismatch("slot_in_use", out_rsp.slot_in_use, e.slot_in_use);
        if (out_rsp.at_end !== e.at_end)
          report_mismatch("at_end", out_rsp.at_end, e.at_end);
        if (out_rsp.next_position !== e.next_position)
          report_mismatch("next_position", out_rsp.next_position, e.next_position);
      end
      rsp_count++;
    end
  end

  // Extremes of every field, every function and the named corner cases
  task automatic test_directed();
    send_req(FN_QUERY, 0, 0, 0);
    send_req(FN_CREATE, 0, 0, 0);
    send_req(FN_PUT, 0, 0, 8'h00);
    send_req(FN_PUT, 0, 31, 8'hFF);
    send_req(FN_PUT, 0, 32, 8'hA5);      // index block and data block on demand
    send_req(FN_PUT, 0, 543, 8'h5A);     // last legal position, far past the size
    send_req(FN_PUT, 0, 544, 8'h11);     // position beyond limit
    send_req(FN_PUT, 0, 1023, 8'h22);
    send_req(FN_GET, 0, 0, 0);
    send_req(FN_GET, 0, 31, 0);
    send_req(FN_GET, 0, 32, 0);
    send_req(FN_GET, 0, 543, 0);
    send_req(FN_GET, 0, 100, 0);         // block missing: zero, no advance
    send_req(FN_GET, 0, 1023, 0);
    send_req(FN_CREATE, 0, 0, 0);        // create on used slot truncates
    send_req(FN_GET, 0, 31, 0);
    send_req(FN_PUT, 5, 7, 8'h3C);       // unused slot still takes bytes
    send_req(FN_GET, 5, 7, 0);
    send_req(FN_DELETE, 11, 0, 0);
    send_req(FN_CREATE, 12, 0, 0);       // bad slot
    send_req(FN_GET, 15, 1023, 0);
    send_req(FN_QUERY, 15, 1023, 0);
    send_req(FN_RSVD6, 5, 3, 8'hFF);
    send_req(FN_RSVD7, 3, 512, 8'h80);
    send_req(FN_FORMAT, 15, 1023, 8'hFF);
    drain();
  endtask

  // Leak one block per round through a sparse delete until the list runs dry
  task automatic test_exhaust();
    send_req(FN_PUT, 3, 32, 8'h77);
    repeat (BLOCKS) begin
      send_req(FN_PUT, 1, 512 + $urandom_range(31), $urandom_range(255));
      send_req(FN_DELETE, 1, 0, 0);
    end
    send_req(FN_PUT, 2, 40, 8'h01);      // needs two blocks
    send_req(FN_PUT, 3, 64, 8'h02);      // needs one block
    send_req(FN_PUT, 3, 33, 8'h03);      // existing block, still fine
    send_req(FN_PUT, 2, 5, 8'h04);       // direct bytes need no block
    send_req(FN_GET, 3, 32, 0);
    send_req(FN_FORMAT, 0, 0, 0);
    drain();
  endtask

  // Hold the receiver off while requests keep coming, then let it drain
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send_req(FN_PUT, 4, i, i * 17);
    drain();
    for (int i = 0; i < 8; i++) send_req(FN_GET, 4, i, 0);
    drain();
  endtask

  // Put runs followed by reads of the same range, mixed with noise
  task automatic test_random(input int n);
    int slot, base, len, pick, done;
    done = 0;
    while (done < n) begin
      calm = (done < 150);
      slot = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(FILES - 1);
      pick = $urandom_range(99);
      if (pick < 60) begin
        base = ($urandom_range(1) == 0) ? $urandom_range(31) : $urandom_range(POS_LIMIT - 1);
        len  = $urandom_range(1, 10);
        if ($urandom_range(3) == 0) send_req(FN_CREATE, slot, 0, 0);
        for (int i = 0; i < len; i++) send_req(FN_PUT, slot, base + i, $urandom_range(255));
        for (int i = 0; i < len; i++) send_req(FN_GET, slot, base + i, 0);
        done += 2 * len;
        if ($urandom_range(4) == 0) begin
          send_req(FN_DELETE, slot, $urandom_range(1023), $urandom_range(255));
          done++;
        end
      end else begin
        pick = $urandom_range(99);
        if (pick < 2) send_req(FN_FORMAT, $urandom_range(15), $urandom_range(1023), 0);
        else if (pick < 10) send_req(FN_CREATE, slot, $urandom_range(1023), 0);
        else if (pick < 18) send_req(FN_DELETE, slot, 0, $urandom_range(255));
        else if (pick < 50) send_req(FN_PUT, slot, $urandom_range(1023), $urandom_range(255));
        else if (pick < 85) send_req(FN_GET, slot, $urandom_range(1023), $urandom_range(255));
        else send_req(3'($urandom_range(5, 7)), slot, $urandom_range(1023),
                      $urandom_range(255));
        done++;
      end
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req      = '0;
    fail_count  = 0;
    rsp_count   = 0;
    req_count   = 0;
    noblk_seen  = 0;
    hold_cycles = 0;
    calm        = 1'b0;
    format_store();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_exhaust();
    test_backpressure();
    test_random(600);

    drain();
    repeat (100) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      fail_count++;
      $display("%0d responses never arrived", expected_rsps.size());
    end
    $display("covered %0d requests, %0d responses, %0d out-of-blocks refusals", req_count,
             rsp_count, noblk_seen);
    $display("directed corners, free list exhaustion, long back-pressure, random runs");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20ms;
    $display("timeout waiting on the block");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
